// File: hw/rtl/mmp_pkg.sv
// Shared types, constants and helpers for the MIDI message parser.
// Used by mmp_front, mmp_back, the top level and the checker; depends on nothing.
package mmp_pkg;

  localparam int unsigned MaxData  = 8;
  localparam int unsigned NumBytes = 8;
  localparam int unsigned CntW     = 4;
  localparam int unsigned IdxW     = $clog2(NumBytes);

  localparam logic [7:0] StNone     = 8'h00;
  localparam logic [7:0] StSysex    = 8'hF0;
  localparam logic [7:0] StMtc      = 8'hF1;
  localparam logic [7:0] StSongPos  = 8'hF2;
  localparam logic [7:0] StSongSel  = 8'hF3;
  localparam logic [7:0] StUndefF4  = 8'hF4;
  localparam logic [7:0] StUndefF5  = 8'hF5;
  localparam logic [7:0] StTuneReq  = 8'hF6;
  localparam logic [7:0] StEox      = 8'hF7;
  localparam logic [7:0] RtUndefF9  = 8'hF9;
  localparam logic [7:0] RtUndefFd  = 8'hFD;

  typedef enum logic [2:0] {
    CmdData  = 3'd0,
    CmdEmit  = 3'd1,
    CmdZero  = 3'd2,
    CmdEox   = 3'd3,
    CmdUndef = 3'd4,
    CmdStart = 3'd5
  } cmd_kind_e;

  typedef logic [6:0] data_byte_t;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [7:0]      value;
    logic [CntW-1:0] need;
    logic            set_rs;
  } cmd_t;

  typedef struct packed {
    logic [7:0]                 status;
    logic [CntW-1:0]            count;
    data_byte_t [NumBytes-1:0]  bytes;
  } result_t;

  function automatic logic [CntW-1:0] voice_need(input logic [7:0] s);
    logic one;
    one = (s[7:4] == 4'hC) || (s[7:4] == 4'hD);
    return one ? CntW'(1) : CntW'(2);
  endfunction

endpackage

// File: hw/rtl/midi_message_parser.sv
// Top level of the MIDI message parser: front classifier, command queue, back parser.
// Depends on mmp_pkg, mmp_front and mmp_back.
//
//   channel   handshake      payload
//   input     push / full    rx_byte_i
//   result    pop / empty    msg_status_o, data_count_o, byte_0_o .. byte_7_o
//
// One word per cycle while full is low; the parser state updates as each command is taken.
// A word is registered in the command queue, then its result in the result queue, from which it can be popped.
// Reset empties both two-entry queues and clears running status and message state.
// A stalled result side fills the result queue, then the command queue, then raises full.
module midi_message_parser import mmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  logic [7:0] rx_byte_i,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] msg_status_o,
  output logic [3:0] data_count_o,
  output logic [6:0] byte_0_o,
  output logic [6:0] byte_1_o,
  output logic [6:0] byte_2_o,
  output logic [6:0] byte_3_o,
  output logic [6:0] byte_4_o,
  output logic [6:0] byte_5_o,
  output logic [6:0] byte_6_o,
  output logic [6:0] byte_7_o
);

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_pop;
  result_t res;

  mmp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rx_byte_i   (rx_byte_i),
    .full_o      (full),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  mmp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign msg_status_o = res.status;
  assign data_count_o = res.count;
  assign byte_0_o     = res.bytes[0];
  assign byte_1_o     = res.bytes[1];
  assign byte_2_o     = res.bytes[2];
  assign byte_3_o     = res.bytes[3];
  assign byte_4_o     = res.bytes[4];
  assign byte_5_o     = res.bytes[5];
  assign byte_6_o     = res.bytes[6];
  assign byte_7_o     = res.bytes[7];

endmodule

// File: hw/rtl/mmp_front.sv
// Front end: accepts received words, classifies them and queues parser commands.
// Depends on mmp_pkg.
module mmp_front import mmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] rx_byte_i,
  output logic       full_o,
  output cmd_t       cmd_o,
  output logic       cmd_valid_o,
  input  logic       cmd_pop_i
);

  cmd_t       cmd_d;
  logic       keep;
  logic       wr_en;
  cmd_t       cmd_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    cmd_d.kind   = CmdData;
    cmd_d.value  = rx_byte_i;
    cmd_d.need   = '0;
    cmd_d.set_rs = 1'b0;
    keep         = 1'b1;
    if (!rx_byte_i[7]) begin
      cmd_d.kind = CmdData;
    end else if (rx_byte_i[7:3] == 5'b11111) begin
      cmd_d.kind = CmdEmit;
      keep = (rx_byte_i != RtUndefF9) && (rx_byte_i != RtUndefFd);
    end else if (rx_byte_i[7:4] == 4'hF) begin
      unique case (rx_byte_i)
        StEox: cmd_d.kind = CmdEox;
        StUndefF4, StUndefF5: cmd_d.kind = CmdUndef;
        StTuneReq: cmd_d.kind = CmdZero;
        StSysex: begin
          cmd_d.kind = CmdStart;
          cmd_d.need = CntW'(MaxData);
        end
        StMtc, StSongSel: begin
          cmd_d.kind = CmdStart;
          cmd_d.need = CntW'(1);
        end
        StSongPos: begin
          cmd_d.kind = CmdStart;
          cmd_d.need = CntW'(2);
        end
        default: cmd_d.kind = CmdUndef;
      endcase
    end else begin
      cmd_d.kind   = CmdStart;
      cmd_d.need   = voice_need(rx_byte_i);
      cmd_d.set_rs = 1'b1;
    end
  end

  assign full_o      = (cnt_q == 2'd2);
  assign wr_en       = push_i && !full_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = cmd_q[rd_q];
  assign cnt_d       = cnt_q + {1'b0, wr_en} - {1'b0, cmd_pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= ~wr_q;
      if (cmd_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) cmd_q[wr_q] <= cmd_d;
  end

endmodule

// File: hw/rtl/mmp_back.sv
// Back end: runs the running-status parser on queued commands and queues results.
// Depends on mmp_pkg.
module mmp_back import mmp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  logic    cmd_valid_i,
  output logic    cmd_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t res_o
);

  logic [7:0]                rs_q, rs_d, cs_q, cs_d, cs_e;
  logic [CntW-1:0]           rem_q, rem_d, rem_e, exp_q, exp_d, exp_e;
  data_byte_t [NumBytes-1:0] buf_q, buf_d;
  logic [IdxW-1:0]           idx;
  logic                      take;
  logic                      emit;
  logic [7:0]                emit_status;
  logic [CntW-1:0]           emit_count;
  result_t                   res_d;
  result_t                   res_q [2];
  logic                      rwr_q, rrd_q;
  logic [1:0]                rcnt_q;
  logic                      room, go, res_push, res_pop;

  assign empty_o   = (rcnt_q == 2'd0);
  assign res_pop   = pop_i && !empty_o;
  assign room      = (rcnt_q != 2'd2) || res_pop;
  assign go        = cmd_valid_i && room;
  assign cmd_pop_o = go;
  assign res_push  = go && emit;
  assign res_o     = res_q[rrd_q];

  always_comb begin
    rs_d        = rs_q;
    cs_d        = cs_q;
    rem_d       = rem_q;
    exp_d       = exp_q;
    buf_d       = buf_q;
    cs_e        = cs_q;
    rem_e       = rem_q;
    exp_e       = exp_q;
    idx         = '0;
    take        = 1'b0;
    emit        = 1'b0;
    emit_status = cmd_i.value;
    emit_count  = '0;
    unique case (cmd_i.kind)
      CmdEmit: emit = 1'b1;
      CmdZero: begin
        rs_d  = StNone;
        cs_d  = cmd_i.value;
        rem_d = '0;
        exp_d = '0;
        emit  = 1'b1;
      end
      CmdEox: begin
        rs_d = StNone;
        if (cs_q == StSysex) begin
          emit        = 1'b1;
          emit_status = StSysex;
          emit_count  = exp_q - rem_q;
        end
        cs_d  = StNone;
        rem_d = '0;
        exp_d = '0;
      end
      CmdUndef: begin
        rs_d  = StNone;
        cs_d  = StNone;
        rem_d = '0;
        exp_d = '0;
      end
      CmdStart: begin
        rs_d  = cmd_i.set_rs ? cmd_i.value : StNone;
        cs_d  = cmd_i.value;
        rem_d = cmd_i.need;
        exp_d = cmd_i.need;
      end
      CmdData: begin
        take = 1'b1;
        if (rem_q == '0) begin
          if (cs_q == StSysex) begin
            take = 1'b0;
          end else if (rs_q == StNone) begin
            take  = 1'b0;
            cs_d  = StNone;
            rem_d = '0;
            exp_d = '0;
          end else begin
            cs_e  = rs_q;
            rem_e = voice_need(rs_q);
            exp_e = voice_need(rs_q);
          end
        end
        if (take) begin
          idx        = IdxW'(exp_e - rem_e);
          buf_d[idx] = cmd_i.value[6:0];
          rem_d      = rem_e - CntW'(1);
          cs_d       = cs_e;
          exp_d      = exp_e;
          if ((rem_d == '0) && (cs_e != StSysex)) begin
            emit        = 1'b1;
            emit_status = cs_e;
            emit_count  = exp_e;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_d.status = emit_status;
    res_d.count  = emit_count;
    for (int k = 0; k < NumBytes; k++) begin
      res_d.bytes[k] = (CntW'(k) < emit_count) ? buf_d[k] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q   <= StNone;
      cs_q   <= StNone;
      rem_q  <= '0;
      exp_q  <= '0;
      buf_q  <= '0;
      rwr_q  <= 1'b0;
      rrd_q  <= 1'b0;
      rcnt_q <= 2'd0;
    end else begin
      if (go) begin
        rs_q  <= rs_d;
        cs_q  <= cs_d;
        rem_q <= rem_d;
        exp_q <= exp_d;
        buf_q <= buf_d;
      end
      if (res_push) rwr_q <= ~rwr_q;
      if (res_pop) rrd_q <= ~rrd_q;
      rcnt_q <= rcnt_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) res_q[rwr_q] <= res_d;
  end

endmodule

// File: hw/rtl/mmp_checker.sv
// Port-level checks on the MIDI message parser, bound to the top level.
// Depends on mmp_pkg and midi_message_parser.
module mmp_checker import mmp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] msg_status_i,
  input logic [3:0] data_count_i,
  input logic [6:0] byte_2_i,
  input logic [6:0] byte_7_i
);

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(msg_status_i) && $stable(data_count_i))
    else $error("waiting result changed or vanished");

  a_status_msb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> msg_status_i[7])
    else $error("result status lacks status bit");

  a_short_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (msg_status_i != StSysex) |-> (data_count_i <= 4'd2) && (byte_2_i == 7'd0))
    else $error("non-sysex message with more than two data words");

  a_sysex_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (data_count_i < 4'd8) |-> (byte_7_i == 7'd0) && (data_count_i <= 4'(MaxData)))
    else $error("unused data word not cleared or count too large");

endmodule

bind midi_message_parser mmp_checker u_mmp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .msg_status_i (msg_status_o),
  .data_count_i (data_count_o),
  .byte_2_i     (byte_2_o),
  .byte_7_i     (byte_7_o)
);
